/* hdl/lanc_pkg.sv */
// Shared types and fixed constants of the LMS adaptive noise canceller.
`default_nettype none

package lanc_pkg;

  localparam int FIELD_W   = 32;
  localparam int COEF_W    = 32;
  localparam int COEF_FRAC = 28;
  localparam int STEP_W    = 24;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'd83886;

  typedef struct packed {
    logic signed [FIELD_W-1:0] primary_sample;
    logic signed [FIELD_W-1:0] reference_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] passthrough_sample;
    logic signed [FIELD_W-1:0] cleaned_sample;
    logic signed [FIELD_W-1:0] noise_estimate;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

`default_nettype wire

/* hdl/lms_adaptive_noise_canceller.sv */
// Top level of the LMS adaptive noise canceller: handshakes, step register, result register.
//
// Usage:
//   Input requests carry a primary and a reference sample (in_valid / in_stall /
//   in_data). Each request yields exactly one result request on out_valid /
//   out_stall / out_data: the primary echoed, the cleaned sample and the noise
//   estimate. cfg_we with cfg_wdata loads the 24-bit step size; the user is to
//   load it only while idle, as the block itself does not enforce this. Each
//   request runs an estimate pass over TAP_COUNT taps, the error and step
//   scaling, and an update pass that uses the one shared multiplier twice per
//   tap. The next request is taken only once the result of the last one has
//   been handed to the output register. in_stall is high while a request is
//   in work.
//   A finished result waits in the output register while the receiver stalls;
//   a new request is then accepted, but its own result is held in the core
//   until the output register frees up.
//   Reset clears the history and coefficients (both read as zero until written)
//   and loads the step size with about 0.005.
`default_nettype none

module lms_adaptive_noise_canceller
  import lanc_pkg::*;
#(
  parameter int TAP_COUNT   = 32,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [STEP_W-1:0] cfg_wdata
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  core_stat_t stat;
  out_item_t  result;
  logic       start;
  logic       take;

  lanc_core #(
    .TAP_COUNT   (TAP_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_data),
    .step_size (step_r),
    .take      (take),
    .stat      (stat),
    .result    (result)
  );

  assign in_stall = !stat.idle;
  assign start    = in_valid && stat.idle;
  // The core hands over its result when the output register is empty or
  // being emptied in this cycle.
  assign take     = stat.done && (!out_valid_r || !out_stall);

  always_comb begin
    step_nxt      = cfg_we ? cfg_wdata : step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* hdl/lanc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lanc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/lanc_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none

module lanc_mul #(
  parameter int A_W = 32,
  parameter int B_W = 34
) (
  input  wire logic                      clk,
  input  wire logic signed [A_W-1:0]     a,
  input  wire logic signed [B_W-1:0]     b,
  output logic      signed [A_W+B_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

`default_nettype wire

/* hdl/lanc_core.sv */
// Sequencer and datapath: estimate pass, error, step scaling and coefficient update.
`default_nettype none

module lanc_core
  import lanc_pkg::*;
#(
  parameter int TAP_COUNT   = 32,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire in_item_t          in_item,
  input  wire logic [STEP_W-1:0] step_size,
  input  wire logic              take,
  output core_stat_t             stat,
  output out_item_t              result
);

  localparam int T   = TAP_COUNT;
  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(T);
  localparam int FW  = $clog2(T + 1);
  localparam int EW  = SB + (COEF_W - COEF_FRAC) + $clog2(T);
  localparam int E   = EW + 1;
  localparam int MW  = E + STEP_W;
  localparam int L   = (MW + 1) / 2;
  localparam int MHW = MW - L;
  localparam int MA  = (SB > STEP_W + 1) ? SB : STEP_W + 1;
  localparam int MB  = (L + 1 > COEF_W) ? L + 1 : COEF_W;
  localparam int PW  = MA + MB;
  localparam int UW  = SB + MW;
  localparam int SH  = 2 * SB - 6;
  localparam int DW  = UW - SH;
  localparam int CW  = DW + 1;

  localparam logic [AW-1:0] LAST = AW'(T - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EST  = 3'd1;
  localparam logic [2:0] S_ERR  = 3'd2;
  localparam logic [2:0] S_MU   = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Control registers
  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          coef_init_r, coef_init_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          iss_r, iss_nxt;
  logic          ph_r, ph_nxt;
  logic [1:0]    mu_cnt_r, mu_cnt_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic          s1_v_r, s1_v_nxt;
  logic          s2_v_r, s2_v_nxt;
  logic          s3_v_r, s3_v_nxt;

  // Payload registers
  logic signed [SB-1:0]     prim_r, prim_nxt;
  logic signed [EW-1:0]     acc_r, acc_nxt;
  logic signed [E-1:0]      err_r, err_nxt;
  logic signed [MW-1:0]     m_r, m_nxt;
  logic [AW-1:0]            d_tap_r, d_tap_nxt;
  logic [AW-1:0]            t1_r, t1_nxt;
  logic [AW-1:0]            t2_r, t2_nxt;
  logic [AW-1:0]            t3_r, t3_nxt;
  logic signed [SB-1:0]     h1_r, h1_nxt;
  logic signed [COEF_W-1:0] c1_r, c1_nxt;
  logic signed [COEF_W-1:0] c2_r, c2_nxt;
  logic signed [COEF_W-1:0] c3_r, c3_nxt;
  logic signed [PW-1:0]     plo_r, plo_nxt;
  logic signed [DW-1:0]     delta_r, delta_nxt;

  // Memories and the shared multiplier
  logic              hist_we;
  logic [AW-1:0]     head_inc;
  logic [SB-1:0]     hist_q;
  logic              coef_we;
  logic [COEF_W-1:0] coef_wd;
  logic [COEF_W-1:0] coef_q;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;

  // Datapath values
  logic [AW-1:0]            ptr_dec;
  logic                     hist_ok;
  logic signed [SB-1:0]     hist_m;
  logic signed [COEF_W-1:0] coef_m;
  logic signed [MW-1:0]     err_x;
  logic signed [L:0]        err_lo_s;
  logic signed [MHW-1:0]    err_hi_s;
  logic signed [L:0]        m_lo_s;
  logic signed [MHW-1:0]    m_hi_s;
  logic signed [EW-1:0]     term;
  logic signed [UW-1:0]     usum;
  logic signed [CW-1:0]     csum;

  lanc_ram #(.WIDTH(SB), .DEPTH(T)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (head_inc),
    .wdata (in_item.reference_sample[SB-1:0]),
    .raddr (ptr_r),
    .rdata (hist_q)
  );

  lanc_ram #(.WIDTH(COEF_W), .DEPTH(T)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (t3_r),
    .wdata (coef_wd),
    .raddr (k_r),
    .rdata (coef_q)
  );

  lanc_mul #(.A_W(MA), .B_W(MB)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  function automatic logic [SB-1:0] sat_smp(input logic signed [E-1:0] v);
    logic [SB-1:0] r;
    if ((&v[E-1:SB-1]) || (~|v[E-1:SB-1])) begin
      r = v[SB-1:0];
    end else if (v[E-1]) begin
      r = {1'b1, {(SB-1){1'b0}}};
    end else begin
      r = {1'b0, {(SB-1){1'b1}}};
    end
    return r;
  endfunction

  assign head_inc = (head_r == LAST) ? '0 : head_r + AW'(1);
  assign ptr_dec  = (ptr_r == '0) ? LAST : ptr_r - AW'(1);
  assign hist_we  = start && (state_r == S_IDLE);

  // History slots beyond the fill count and coefficients before the first
  // update have never been written and read as zero.
  assign hist_ok = (FW'(d_tap_r) < fill_r);
  assign hist_m  = hist_ok ? $signed(hist_q) : '0;
  assign coef_m  = coef_init_r ? $signed(coef_q) : '0;

  assign err_x    = MW'(err_r);
  assign err_lo_s = $signed({1'b0, err_x[L-1:0]});
  assign err_hi_s = $signed(err_x[MW-1:L]);
  assign m_lo_s   = $signed({1'b0, m_r[L-1:0]});
  assign m_hi_s   = $signed(m_r[MW-1:L]);

  assign term = EW'(prod >>> COEF_FRAC);
  // The full update product is split at bit L; the high half arrives in the
  // cycle after the low half.
  assign usum = UW'(plo_r) + (UW'(prod) <<< L);
  assign csum = CW'(c3_r) + CW'(delta_r);

  always_comb begin
    if ((&csum[CW-1:COEF_W-1]) || (~|csum[CW-1:COEF_W-1])) begin
      coef_wd = csum[COEF_W-1:0];
    end else if (csum[CW-1]) begin
      coef_wd = {1'b1, {(COEF_W-1){1'b0}}};
    end else begin
      coef_wd = {1'b0, {(COEF_W-1){1'b1}}};
    end
  end

  always_comb begin
    mul_a = MA'(hist_m);
    mul_b = MB'(coef_m);
    case (state_r)
      S_MU: begin
        mul_a = MA'($signed({1'b0, step_size}));
        if (mu_cnt_r == 2'd0) begin
          mul_b = MB'(err_lo_s);
        end else begin
          mul_b = MB'(err_hi_s);
        end
      end
      S_UPD: begin
        if (s1_v_r) begin
          mul_a = MA'(h1_r);
          mul_b = MB'(m_hi_s);
        end else begin
          mul_b = MB'(m_lo_s);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    coef_init_nxt = coef_init_r;
    k_nxt         = k_r;
    ptr_nxt       = ptr_r;
    iss_nxt       = iss_r;
    ph_nxt        = ph_r;
    mu_cnt_nxt    = mu_cnt_r;
    prim_nxt      = prim_r;
    acc_nxt       = acc_r;
    err_nxt       = err_r;
    m_nxt         = m_r;

    rd_v_nxt  = 1'b0;
    d_tap_nxt = k_r;
    s1_v_nxt  = rd_v_r;
    t1_nxt    = d_tap_r;
    h1_nxt    = hist_m;
    c1_nxt    = coef_m;
    s2_v_nxt  = s1_v_r && (state_r == S_UPD);
    t2_nxt    = t1_r;
    c2_nxt    = c1_r;
    plo_nxt   = prod;
    s3_v_nxt  = s2_v_r;
    t3_nxt    = t2_r;
    c3_nxt    = c2_r;
    delta_nxt = DW'(usum >>> SH);
    coef_we   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EST;
          head_nxt  = head_inc;
          ptr_nxt   = head_inc;
          k_nxt     = '0;
          iss_nxt   = 1'b1;
          acc_nxt   = '0;
          prim_nxt  = $signed(in_item.primary_sample[SB-1:0]);
          fill_nxt  = (fill_r == FW'(T)) ? fill_r : fill_r + FW'(1);
        end
      end
      S_EST: begin
        if (iss_r) begin
          rd_v_nxt = 1'b1;
          ptr_nxt  = ptr_dec;
          if (k_r == LAST) begin
            iss_nxt = 1'b0;
          end else begin
            k_nxt = k_r + AW'(1);
          end
        end
        if (s1_v_r) begin
          acc_nxt = acc_r + term;
          if (t1_r == LAST) begin
            state_nxt = S_ERR;
          end
        end
      end
      S_ERR: begin
        err_nxt    = E'(prim_r) - E'(acc_r);
        mu_cnt_nxt = 2'd0;
        state_nxt  = S_MU;
      end
      S_MU: begin
        // step_size times error, formed from two partial products.
        if (mu_cnt_r == 2'd0) begin
          mu_cnt_nxt = 2'd1;
        end else if (mu_cnt_r == 2'd1) begin
          m_nxt      = MW'(prod);
          mu_cnt_nxt = 2'd2;
        end else begin
          m_nxt     = m_r + (MW'(prod) <<< L);
          state_nxt = S_UPD;
          k_nxt     = '0;
          ptr_nxt   = head_r;
          iss_nxt   = 1'b1;
          ph_nxt    = 1'b0;
        end
      end
      S_UPD: begin
        // A tap is issued only while the phase bit ph_r is low; the phase toggles
        // so that each tap gets the multiplier twice.
        ph_nxt = ~ph_r;
        if (iss_r && !ph_r) begin
          rd_v_nxt = 1'b1;
          ptr_nxt  = ptr_dec;
          if (k_r == LAST) begin
            iss_nxt = 1'b0;
          end else begin
            k_nxt = k_r + AW'(1);
          end
        end
        if (s3_v_r) begin
          coef_we = 1'b1;
          if (t3_r == LAST) begin
            state_nxt     = S_DONE;
            coef_init_nxt = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      coef_init_r <= 1'b0;
      k_r         <= '0;
      ptr_r       <= '0;
      iss_r       <= 1'b0;
      ph_r        <= 1'b0;
      mu_cnt_r    <= 2'd0;
      rd_v_r      <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      coef_init_r <= coef_init_nxt;
      k_r         <= k_nxt;
      ptr_r       <= ptr_nxt;
      iss_r       <= iss_nxt;
      ph_r        <= ph_nxt;
      mu_cnt_r    <= mu_cnt_nxt;
      rd_v_r      <= rd_v_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      s3_v_r      <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prim_r  <= prim_nxt;
    acc_r   <= acc_nxt;
    err_r   <= err_nxt;
    m_r     <= m_nxt;
    d_tap_r <= d_tap_nxt;
    t1_r    <= t1_nxt;
    t2_r    <= t2_nxt;
    t3_r    <= t3_nxt;
    h1_r    <= h1_nxt;
    c1_r    <= c1_nxt;
    c2_r    <= c2_nxt;
    c3_r    <= c3_nxt;
    plo_r   <= plo_nxt;
    delta_r <= delta_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_DONE);

  assign result.passthrough_sample = FIELD_W'(prim_r);
  assign result.cleaned_sample     = FIELD_W'($signed(sat_smp(err_r)));
  assign result.noise_estimate     = FIELD_W'($signed(sat_smp(E'(acc_r))));

endmodule

`default_nettype wire
